// ----- src/cfbm_pkg.sv -----
package cfbm_pkg;

	// Item mode codes
	typedef enum logic [1:0] {
		MODE_RESTART  = 2'd0,
		MODE_EDGE     = 2'd1,
		MODE_EVALUATE = 2'd2,
		MODE_NONE     = 2'd3
	} mode_t;

	// Evaluation verdict codes
	typedef enum logic [1:0] {
		VERDICT_OK    = 2'd0,
		VERDICT_BAD   = 2'd1,
		VERDICT_FLASH = 2'd2
	} verdict_t;

	// Configuration register indexes (byte address is four times the index)
	typedef enum logic [2:0] {
		REG_COUNTER_MAX     = 3'd0,
		REG_CLOCK_RATE_HZ   = 3'd1,
		REG_EDGE_TIMEOUT_MS = 3'd2,
		REG_TARGET_HZ       = 3'd3,
		REG_TOLERANCE_HZ    = 3'd4,
		REG_STRIKE_LIMIT    = 3'd5
	} reg_idx_t;

	localparam int DEF_COUNT_BITS = 32;
	localparam int DEF_TIME_BITS  = 32;

	localparam int FIELD_W = 32;
	localparam int ADDR_W  = 5;
	localparam int DIV_BITS = 32;

	localparam logic [7:0] BYTE_MAX = 8'hFF;

	localparam logic [31:0] RST_COUNTER_MAX     = 32'd65535;
	localparam logic [31:0] RST_CLOCK_RATE_HZ   = 32'd1000000;
	localparam logic [31:0] RST_EDGE_TIMEOUT_MS = 32'd1000;
	localparam logic [7:0]  RST_TARGET_HZ       = 8'd50;
	localparam logic [7:0]  RST_TOLERANCE_HZ    = 8'd5;
	localparam logic [7:0]  RST_STRIKE_LIMIT    = 8'd3;

endpackage

// ----- src/capture_frequency_band_monitor_core.sv -----
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    mode, capture_count, now_ms
// result    out        result_valid / result_stall  measured, verdict, frequency_hz
// config    in         APB write/read             paddr, pwdata, prdata
//
// One item is taken at a time; item_stall is low only while the sequencer is idle.
// Restart, evaluate, priming-edge and unused-mode items pass from the execute state
// straight to the result stage, which loads the output register and frees the sequencer.
// A measuring edge first passes the wrap state (for a wrapped count) and the 32-step
// restoring divider that turns the period into a frequency one quotient bit per cycle;
// equal counts, or a wrapped period of zero, skip the divider.
// Reset (arst_n low) clears the monitor state and loads the register defaults.
// A stalled result holds in the output register; the next item is still taken, but its
// result waits in the sequencer until the output register is free.
module capture_frequency_band_monitor_core #(
	parameter int COUNT_BITS = cfbm_pkg::DEF_COUNT_BITS,
	parameter int TIME_BITS  = cfbm_pkg::DEF_TIME_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    mode,
	input  logic [cfbm_pkg::FIELD_W-1:0]  capture_count,
	input  logic [cfbm_pkg::FIELD_W-1:0]  now_ms,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          measured,
	output logic [1:0]                    verdict,
	output logic [7:0]                    frequency_hz,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cfbm_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import cfbm_pkg::*;

	localparam int DIV_CNT_W = $clog2(DIV_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WRAP,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [31:0] counter_max_q;
	logic [31:0] clock_rate_q;
	logic [31:0] timeout_q;
	logic [7:0]  target_q;
	logic [7:0]  tolerance_q;
	logic [7:0]  strike_q;

	// Monitor state
	logic [COUNT_BITS-1:0] prev_count_q;
	logic [TIME_BITS-1:0]  last_edge_q;
	logic [7:0]            bad_streak_q;
	logic [7:0]            freq_q;
	logic                  primed_q;

	// Latched item and working registers
	mode_t                 mode_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [31:0]           diff_q;
	logic [31:0]           period_q;
	logic [31:0]           quo_q;
	logic [31:0]           rem_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic                  res_measured_q;
	verdict_t              res_verdict_q;

	// Output register
	logic       result_valid_q;
	logic       measured_q;
	verdict_t   verdict_q;
	logic [7:0] frequency_q;

	logic [2:0] reg_idx;
	logic       cfg_write;

	logic [31:0]          count_ext;
	logic [31:0]          prev_ext;
	logic [31:0]          diff;
	logic [31:0]          wrap_period;
	logic [TIME_BITS-1:0] elapsed;
	logic                 lost;
	logic [7:0]           band_lo;
	logic [8:0]           band_sum;
	logic [7:0]           band_hi;
	logic [7:0]           freq_eval;
	logic                 in_band;
	logic [7:0]           streak_inc;
	logic [32:0]          div_shifted;
	logic [33:0]          div_trial;
	logic                 div_ge;
	logic [31:0]          div_rem_next;
	logic                 out_free;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	// Register write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_max_q <= RST_COUNTER_MAX;
			clock_rate_q  <= RST_CLOCK_RATE_HZ;
			timeout_q     <= RST_EDGE_TIMEOUT_MS;
			target_q      <= RST_TARGET_HZ;
			tolerance_q   <= RST_TOLERANCE_HZ;
			strike_q      <= RST_STRIKE_LIMIT;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_COUNTER_MAX:     counter_max_q <= pwdata;
				REG_CLOCK_RATE_HZ:   clock_rate_q  <= pwdata;
				REG_EDGE_TIMEOUT_MS: timeout_q     <= pwdata;
				REG_TARGET_HZ:       target_q      <= pwdata[7:0];
				REG_TOLERANCE_HZ:    tolerance_q   <= pwdata[7:0];
				REG_STRIKE_LIMIT:    strike_q      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register read port
	always_comb begin
		unique case (reg_idx)
			REG_COUNTER_MAX:     prdata = counter_max_q;
			REG_CLOCK_RATE_HZ:   prdata = clock_rate_q;
			REG_EDGE_TIMEOUT_MS: prdata = timeout_q;
			REG_TARGET_HZ:       prdata = {24'd0, target_q};
			REG_TOLERANCE_HZ:    prdata = {24'd0, tolerance_q};
			REG_STRIKE_LIMIT:    prdata = {24'd0, strike_q};
			default:             prdata = 32'd0;
		endcase
	end

	// Count difference, modulo 2^32, and the wrapped period
	assign count_ext   = 32'(count_q);
	assign prev_ext    = 32'(prev_count_q);
	assign diff        = count_ext - prev_ext;
	assign wrap_period = counter_max_q + diff_q + 32'd1;

	// Edge timeout and acceptance band
	assign elapsed    = now_q - last_edge_q;
	assign lost       = !primed_q || (32'(elapsed) > timeout_q);
	assign band_lo    = (target_q > tolerance_q) ? (target_q - tolerance_q) : 8'd0;
	assign band_sum   = {1'b0, target_q} + {1'b0, tolerance_q};
	assign band_hi    = band_sum[8] ? BYTE_MAX : band_sum[7:0];
	assign freq_eval  = lost ? 8'd0 : freq_q;
	assign in_band    = !lost && (freq_eval >= band_lo) && (freq_eval <= band_hi);
	assign streak_inc = (bad_streak_q == BYTE_MAX) ? bad_streak_q : bad_streak_q + 8'd1;

	// One restoring division step: shift in the next dividend bit, try to subtract
	assign div_shifted  = {rem_q, quo_q[DIV_BITS-1]};
	assign div_trial    = {1'b0, div_shifted} - {2'b00, period_q};
	assign div_ge       = !div_trial[33];
	assign div_rem_next = div_ge ? div_trial[31:0] : div_shifted[31:0];

	assign out_free = !result_valid_q || !result_stall;

	// Item sequencer, monitor state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			prev_count_q   <= '0;
			last_edge_q    <= '0;
			bad_streak_q   <= 8'd0;
			freq_q         <= 8'd0;
			primed_q       <= 1'b0;
			mode_q         <= MODE_RESTART;
			count_q        <= '0;
			now_q          <= '0;
			diff_q         <= 32'd0;
			period_q       <= 32'd0;
			quo_q          <= 32'd0;
			rem_q          <= 32'd0;
			div_cnt_q      <= '0;
			res_measured_q <= 1'b0;
			res_verdict_q  <= VERDICT_OK;
			result_valid_q <= 1'b0;
			measured_q     <= 1'b0;
			verdict_q      <= VERDICT_OK;
			frequency_q    <= 8'd0;
		end else begin
			// The result stage reloads the output register itself when it hands over.
			if (result_valid_q && !result_stall && (state_q != ST_DONE))
				result_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						mode_q  <= mode_t'(mode);
						count_q <= capture_count[COUNT_BITS-1:0];
						now_q   <= now_ms[TIME_BITS-1:0];
						state_q <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					unique case (mode_q)
						MODE_RESTART: begin
							prev_count_q   <= '0;
							last_edge_q    <= now_q;
							bad_streak_q   <= 8'd0;
							freq_q         <= 8'd0;
							primed_q       <= 1'b0;
							res_measured_q <= 1'b0;
							res_verdict_q  <= VERDICT_OK;
							state_q        <= ST_DONE;
						end
						MODE_EDGE: begin
							last_edge_q   <= now_q;
							prev_count_q  <= count_q;
							res_verdict_q <= VERDICT_OK;
							if (!primed_q) begin
								primed_q       <= 1'b1;
								res_measured_q <= 1'b0;
								state_q        <= ST_DONE;
							end else begin
								res_measured_q <= 1'b1;
								if (count_q == prev_count_q) begin
									freq_q   <= 8'd0;
									primed_q <= 1'b0;
									state_q  <= ST_DONE;
								end else if (count_q > prev_count_q) begin
									period_q <= diff;
									state_q  <= ST_DIV;
								end else begin
									diff_q  <= diff;
									state_q <= ST_WRAP;
								end
							end
						end
						MODE_EVALUATE: begin
							res_measured_q <= 1'b0;
							state_q        <= ST_DONE;
							if (lost) begin
								freq_q   <= 8'd0;
								primed_q <= 1'b0;
							end
							if (in_band) begin
								bad_streak_q  <= 8'd0;
								res_verdict_q <= VERDICT_OK;
							end else begin
								bad_streak_q  <= streak_inc;
								res_verdict_q <= (streak_inc >= strike_q) ?
									VERDICT_FLASH : VERDICT_BAD;
							end
						end
						default: begin
							res_measured_q <= 1'b0;
							res_verdict_q  <= VERDICT_OK;
							state_q        <= ST_DONE;
						end
					endcase
					quo_q     <= clock_rate_q;
					rem_q     <= 32'd0;
					div_cnt_q <= DIV_CNT_W'(DIV_BITS - 1);
				end

				// A wrapped period of zero leaves the frequency at zero, still primed
				ST_WRAP: begin
					period_q <= wrap_period;
					if (wrap_period == 32'd0) begin
						freq_q  <= 8'd0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end

				ST_DIV: begin
					quo_q     <= {quo_q[DIV_BITS-2:0], div_ge};
					rem_q     <= div_rem_next;
					div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
					if (div_cnt_q == '0) begin
						freq_q  <= {quo_q[6:0], div_ge};
						state_q <= ST_DONE;
					end
				end

				ST_DONE: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						measured_q     <= res_measured_q;
						verdict_q      <= res_verdict_q;
						frequency_q    <= freq_q;
						state_q        <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign measured     = measured_q;
	assign verdict      = verdict_q;
	assign frequency_hz = frequency_q;

	// While unprimed, every path that got there left the frequency at zero.
	a_unprimed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!primed_q |-> (freq_q == 8'd0))
		else $error("frequency nonzero while unprimed");

	// An accepted transaction keeps the item channel stalled in the next cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("second item accepted while one is in flight");

	// A result never carries both a measurement flag and a verdict.
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(measured && (verdict != VERDICT_OK)))
		else $error("result marks both an edge and an evaluation");

	// The divider finishes by handing the result stage a pending result.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q == '0) |=> (state_q == ST_DONE && res_measured_q))
		else $error("divider ended without a measured result");

endmodule
